@@ src/usan_pkg.sv @@
// Shared types, constants and byte-check functions for the URI path sanitizer.
package usan_pkg;

  // Characters the checks look at
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // UTF-8 limits
  localparam logic [20:0] UTF8_MAX   = 21'h10FFFF;
  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;
  localparam logic [7:0]  LEAD2_MIN  = 8'hC2;
  localparam logic [7:0]  LEAD2_MAX  = 8'hDF;
  localparam logic [7:0]  LEAD3_MIN  = 8'hE0;
  localparam logic [7:0]  LEAD3_MAX  = 8'hEF;
  localparam logic [7:0]  LEAD4_MIN  = 8'hF0;
  localparam logic [7:0]  LEAD4_MAX  = 8'hF4;

  // Minimum code point classes of a multi-byte sequence
  localparam logic [1:0] UCLS_TWO   = 2'd1;
  localparam logic [1:0] UCLS_THREE = 2'd2;
  localparam logic [1:0] UCLS_FOUR  = 2'd3;

  // Reserved device stems, upper case
  localparam logic [23:0] DEV_CON = 24'h434F4E;
  localparam logic [23:0] DEV_PRN = 24'h50524E;
  localparam logic [23:0] DEV_AUX = 24'h415558;
  localparam logic [23:0] DEV_NUL = 24'h4E554C;
  localparam logic [23:0] DEV_COM = 24'h434F4D;
  localparam logic [23:0] DEV_LPT = 24'h4C5054;

  localparam logic [11:0] PATH_ROOM_RESET = 12'd255;

  typedef logic [3:0][7:0] stem_t;

  // One decoded word handed from the front to the back
  typedef struct packed {
    logic [7:0] ch;
    logic       have;
    logic       escaped;
    logic       bad;
    logic       esc_open;
    logic       last;
  } q_item_t;

  // Return {valid, nibble} for a hex digit of either case
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  function automatic logic is_forbidden(input logic [7:0] c);
    return (c <= 8'd31) || (c == 8'h7F) || (c == 8'h3A) || (c == CH_BSLASH) ||
           (c == 8'h3F) || (c == 8'h23) || (c == 8'h24) || (c == 8'h2A) ||
           (c == 8'h7C) || (c == 8'h3C) || (c == 8'h3E) || (c == 8'h22) ||
           (c == CH_PERCENT);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
  endfunction

  // A segment is safe when nonempty, not ending in dot or space, not a device
  function automatic logic segment_safe(input logic nonempty, input logic [7:0] last_ch,
                                        input logic [2:0] len, input stem_t chars);
    logic [23:0] stem3;
    logic        digit;
    logic        r;
    stem3 = {chars[0], chars[1], chars[2]};
    digit = (chars[3] >= 8'h31) && (chars[3] <= 8'h39);
    r = 1'b1;
    if (!nonempty || last_ch == CH_DOT || last_ch == CH_SPACE) begin
      r = 1'b0;
    end else if (len == 3'd3) begin
      r = !(stem3 == DEV_CON || stem3 == DEV_PRN || stem3 == DEV_AUX || stem3 == DEV_NUL);
    end else if (len == 3'd4) begin
      r = !((stem3 == DEV_COM || stem3 == DEV_LPT) && digit);
    end
    return r;
  endfunction

endpackage

@@ src/usan_front.sv @@
// Front end: accepts raw URI bytes and resolves percent escapes.
module usan_front import usan_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] uri_byte,
  input  logic       last,
  input  logic       q_ready,
  output logic       q_push,
  output q_item_t    q_item
);

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  logic [1:0] escape_phase, escape_phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic [4:0] hv;

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  // Classify the byte against the escape state
  always_comb begin
    hv                = hex_digit(uri_byte);
    escape_phase_next = escape_phase;
    high_nibble_next  = high_nibble;
    q_item            = '0;
    q_item.last       = last;
    case (escape_phase)
      ESC_IDLE: begin
        if (uri_byte == CH_PERCENT) begin
          escape_phase_next = ESC_HIGH;
        end else begin
          q_item.ch   = uri_byte;
          q_item.have = 1'b1;
        end
      end
      ESC_HIGH: begin
        if (!hv[4]) begin
          q_item.bad = 1'b1;
        end else begin
          high_nibble_next  = hv[3:0];
          escape_phase_next = ESC_LOW;
        end
      end
      ESC_LOW: begin
        if (!hv[4]) begin
          q_item.bad = 1'b1;
        end else begin
          q_item.ch         = {high_nibble, hv[3:0]};
          q_item.have       = 1'b1;
          q_item.escaped    = 1'b1;
          escape_phase_next = ESC_IDLE;
        end
      end
      default: begin
        escape_phase_next = ESC_IDLE;
      end
    endcase
    q_item.esc_open = last && (escape_phase_next != ESC_IDLE);
  end

  // Advance escape state; drop it at the end of a URI
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_phase <= ESC_IDLE;
      high_nibble  <= 4'd0;
    end else if (q_push) begin
      if (last) begin
        escape_phase <= ESC_IDLE;
        high_nibble  <= 4'd0;
      end else begin
        escape_phase <= escape_phase_next;
        high_nibble  <= high_nibble_next;
      end
    end
  end

endmodule

@@ src/usan_queue.sv @@
// Small queue of decoded words between front and back.
module usan_queue import usan_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    push_ready,
  input  logic    pop,
  output logic    pop_valid,
  output q_item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  q_item_t       slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ src/usan_back.sv @@
// Back end: checks decoded bytes, tracks segments and UTF-8, gives the verdict.
module usan_back import usan_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [11:0] path_room,
  input  logic        q_valid,
  input  q_item_t     q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  path_byte,
  output logic        path_byte_valid,
  output logic        done_res,
  output logic        accepted
);

  logic        failed, failed_next;
  logic [11:0] decoded_count, decoded_count_next;
  logic        seg_nonempty, seg_nonempty_next;
  logic [7:0]  seg_last, seg_last_next;
  logic [2:0]  stem_len, stem_len_next;
  logic        stem_closed, stem_closed_next;
  stem_t       stem_chars, stem_chars_next;
  logic [1:0]  u_pend, u_pend_next, u_pend_dec;
  logic [20:0] u_val, u_val_next, u_val_cont;
  logic [1:0]  u_cls, u_cls_next;

  logic [7:0]  c;
  logic        is_slash;
  logic        u_ok;
  logic [20:0] u_min;
  logic        ok;
  logic        step_ok;
  logic        final_fail;
  logic        take;

  assign take  = q_valid && (!out_valid || out_ready);
  assign q_pop = take;
  assign c     = q_item.ch;
  assign is_slash = (c == CH_SLASH);

  // UTF-8 sequence step for the candidate byte
  always_comb begin
    u_ok       = 1'b1;
    u_pend_next = u_pend;
    u_val_next  = u_val;
    u_cls_next  = u_cls;
    u_pend_dec  = u_pend - 2'd1;
    u_val_cont  = {u_val[14:0], c[5:0]};
    case (u_cls)
      UCLS_TWO:   u_min = 21'h000080;
      UCLS_THREE: u_min = 21'h000800;
      default:    u_min = 21'h010000;
    endcase
    if (u_pend != 2'd0) begin
      if (c[7:6] != 2'b10) u_ok = 1'b0;
      u_val_next  = u_val_cont;
      u_pend_next = u_pend_dec;
      if (u_pend_dec == 2'd0) begin
        if (u_val_cont < u_min || u_val_cont > UTF8_MAX ||
            (u_val_cont >= SURR_LO && u_val_cont <= SURR_HI)) u_ok = 1'b0;
      end
    end else if (c[7] == 1'b0) begin
      u_ok = 1'b1;
    end else if (c >= LEAD2_MIN && c <= LEAD2_MAX) begin
      u_val_next = {16'd0, c[4:0]}; u_pend_next = 2'd1; u_cls_next = UCLS_TWO;
    end else if (c >= LEAD3_MIN && c <= LEAD3_MAX) begin
      u_val_next = {17'd0, c[3:0]}; u_pend_next = 2'd2; u_cls_next = UCLS_THREE;
    end else if (c >= LEAD4_MIN && c <= LEAD4_MAX) begin
      u_val_next = {18'd0, c[2:0]}; u_pend_next = 2'd3; u_cls_next = UCLS_FOUR;
    end else begin
      u_ok = 1'b0;
    end
  end

  // Check the byte and compute the next path state
  always_comb begin
    ok = !(q_item.escaped && (is_slash || c == CH_BSLASH)) &&
         !is_forbidden(c) &&
         !(is_slash && !segment_safe(seg_nonempty, seg_last, stem_len, stem_chars)) &&
         (decoded_count < path_room) && u_ok;
    step_ok = !failed && !q_item.bad && q_item.have && ok;
    failed_next = failed || q_item.bad || (q_item.have && !ok);

    decoded_count_next = decoded_count;
    seg_nonempty_next  = seg_nonempty;
    seg_last_next      = seg_last;
    stem_len_next      = stem_len;
    stem_closed_next   = stem_closed;
    stem_chars_next    = stem_chars;
    if (step_ok) begin
      decoded_count_next = decoded_count + 12'd1;
      if (is_slash) begin
        seg_nonempty_next = 1'b0;
        seg_last_next     = 8'd0;
        stem_len_next     = 3'd0;
        stem_closed_next  = 1'b0;
        stem_chars_next   = '0;
      end else begin
        seg_nonempty_next = 1'b1;
        seg_last_next     = c;
        if (!stem_closed) begin
          if (c == CH_DOT) begin
            stem_closed_next = 1'b1;
          end else begin
            if (stem_len < 3'd4) stem_chars_next[stem_len[1:0]] = to_upper(c);
            if (stem_len < 3'd5) stem_len_next = stem_len + 3'd1;
          end
        end
      end
    end

    final_fail = failed_next || q_item.esc_open ||
                 !segment_safe(seg_nonempty_next, seg_last_next, stem_len_next,
                               stem_chars_next) ||
                 (step_ok ? (u_pend_next != 2'd0) : (u_pend != 2'd0));
  end

  // Register the result word and hold path state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      failed        <= 1'b0;
      decoded_count <= 12'd0;
      seg_nonempty  <= 1'b0;
      seg_last      <= 8'd0;
      stem_len      <= 3'd0;
      stem_closed   <= 1'b0;
      stem_chars    <= '0;
      u_pend        <= 2'd0;
      u_val         <= 21'd0;
      u_cls         <= 2'd0;
    end else if (take) begin
      out_valid       <= 1'b1;
      path_byte       <= step_ok ? c : 8'd0;
      path_byte_valid <= step_ok;
      done_res        <= q_item.last;
      accepted        <= q_item.last && !final_fail;
      if (q_item.last) begin
        failed        <= 1'b0;
        decoded_count <= 12'd0;
        seg_nonempty  <= 1'b0;
        seg_last      <= 8'd0;
        stem_len      <= 3'd0;
        stem_closed   <= 1'b0;
        stem_chars    <= '0;
        u_pend        <= 2'd0;
        u_val         <= 21'd0;
        u_cls         <= 2'd0;
      end else begin
        failed        <= failed_next;
        decoded_count <= decoded_count_next;
        seg_nonempty  <= seg_nonempty_next;
        seg_last      <= seg_last_next;
        stem_len      <= stem_len_next;
        stem_closed   <= stem_closed_next;
        stem_chars    <= stem_chars_next;
        if (step_ok) begin
          u_pend <= u_pend_next;
          u_val  <= u_val_next;
          u_cls  <= u_cls_next;
        end
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ src/uri_path_sanitizer_top.sv @@
// Top level of the URI path sanitizer: config register, front, queue, back.
// An accepted byte goes into the queue; the back end then registers its result word.
// Throughput: one byte per cycle unless out_ready stalls the back; the front escape
// decoder and back checker each take one word per cycle, and the queue lets either side
// stall while the other runs. Reset (synchronous, active high) clears all path state and
// the queue; path_room returns to 255.
module uri_path_sanitizer_top import usan_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  uri_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  path_byte,
  output logic        path_byte_valid,
  output logic        done_res,
  output logic        accepted
);

  localparam logic [2:0] ADDR_PATH_ROOM = 3'd0;

  logic [11:0] path_room;
  q_item_t     f_item;
  q_item_t     b_item;
  logic        f_push;
  logic        f_ready;
  logic        b_valid;
  logic        b_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_PATH_ROOM) ? {20'd0, path_room} : 32'd0;

  // Write the room register
  always_ff @(posedge clk) begin
    if (rst) begin
      path_room <= PATH_ROOM_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_PATH_ROOM) begin
      path_room <= pwdata[11:0];
    end
  end

  usan_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .uri_byte (uri_byte),
    .last     (last),
    .q_ready  (f_ready),
    .q_push   (f_push),
    .q_item   (f_item)
  );

  usan_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_item  (f_item),
    .push_ready (f_ready),
    .pop        (b_pop),
    .pop_valid  (b_valid),
    .pop_item   (b_item)
  );

  usan_back u_back (
    .clk             (clk),
    .rst             (rst),
    .path_room       (path_room),
    .q_valid         (b_valid),
    .q_item          (b_item),
    .q_pop           (b_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .path_byte       (path_byte),
    .path_byte_valid (path_byte_valid),
    .done_res        (done_res),
    .accepted        (accepted)
  );

  // A safe verdict only comes with the end of a URI
  assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> done_res)
    else $error("accepted without done_res");

  // Bytes not emitted read as zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !path_byte_valid |-> path_byte == 8'd0)
    else $error("path_byte nonzero without valid");

  // No result word right after reset
  assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("out_valid set after reset");

  // The queue never pops without a stored word
  assert property (@(posedge clk) disable iff (rst)
    b_pop |-> b_valid)
    else $error("queue popped while empty");

endmodule
